### rtl/drb_pkg.sv
`default_nettype none

package drb_pkg;

   localparam int COORD_BITS = 12;
   localparam int OUT_BITS   = 20;

   localparam int DEPTH_W    = 16;
   localparam int ROI_W      = 12;
   localparam int STRIDE_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int ROI_REG_W  = 56;
   localparam int RANGE_W    = 32;

   localparam int CMP_W      = (COORD_BITS > ROI_W) ? COORD_BITS : ROI_W;
   localparam int REM_STAGES = 4;
   localparam int REM_STEPS  = (CMP_W + REM_STAGES - 1) / REM_STAGES;
   localparam int DIV_W      = REM_STAGES * REM_STEPS;

   localparam int SCALE_W     = 16;
   localparam int CENTRE_W    = 16;
   localparam int CENTRE_FRAC = 4;
   localparam int INVF_W      = 32;
   localparam int COEF_W      = 16;
   localparam int INVF_SHIFT  = 24;
   localparam int CAM_SHIFT   = 8;
   localparam int WORLD_SHIFT = 22;

   localparam int U_W   = COORD_BITS + SCALE_W;
   localparam int DU_W  = U_W + 1;
   localparam int MAG_W = U_W;
   localparam int P_W   = MAG_W + INVF_W;
   localparam int T_W   = P_W - INVF_SHIFT + 1;
   localparam int Q_W   = T_W + DEPTH_W;
   localparam int C_W   = Q_W - CAM_SHIFT + 1;
   localparam int CAM_W = C_W + 1;
   localparam int PR_W  = COEF_W + CAM_W;
   localparam int W_W   = PR_W + 2;
   localparam int R_W   = W_W - WORLD_SHIFT;

   localparam int PIPE_STAGES  = 9;
   localparam int ST_IN        = 0;
   localparam int ST_REM_FIRST = 1;
   localparam int ST_MAG       = 1;
   localparam int ST_PROD      = 2;
   localparam int ST_TRUNC     = 3;
   localparam int ST_SCALE     = 4;
   localparam int ST_REM_LAST  = ST_REM_FIRST + REM_STAGES - 1;
   localparam int ST_CAM       = 5;
   localparam int ST_ROT       = 6;
   localparam int ST_SUM       = 7;
   localparam int ST_OUT       = PIPE_STAGES - 1;

   typedef logic [PIPE_STAGES-1:0] stage_vec_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROI,
      CSR_RANGE,
      CSR_GEOM,
      CSR_INVF,
      CSR_ROW_X,
      CSR_ROW_Y,
      CSR_ROW_Z
   } csr_index_type;

   localparam logic [ROI_REG_W-1:0]  ROI_RESET   = '0;
   localparam logic [RANGE_W-1:0]    RANGE_RESET = 32'hFFFF_0000;
   localparam logic [CSR_DATA_W-1:0] GEOM_RESET  = 64'h0000_0000_0100_0100;
   localparam logic [CSR_DATA_W-1:0] INVF_RESET  = '0;
   localparam logic [CSR_DATA_W-1:0] ROWX_RESET  = 64'h0000_0000_0000_4000;
   localparam logic [CSR_DATA_W-1:0] ROWY_RESET  = 64'h0000_0000_4000_0000;
   localparam logic [CSR_DATA_W-1:0] ROWZ_RESET  = 64'h0000_4000_0000_0000;

endpackage

`default_nettype wire

### rtl/drb_ifs.sv
`default_nettype none

interface drb_req_if;
   logic                                valid;
   logic                                ready;
   logic [drb_pkg::DEPTH_W-1:0]         depth;
   logic [drb_pkg::COORD_BITS-1:0]      column;
   logic [drb_pkg::COORD_BITS-1:0]      row;

   modport source (output valid, depth, column, row, input ready);
   modport sink   (input valid, depth, column, row, output ready);
endinterface

interface drb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [drb_pkg::OUT_BITS-1:0] world_x;
   logic signed [drb_pkg::OUT_BITS-1:0] world_y;
   logic signed [drb_pkg::OUT_BITS-1:0] world_z;

   modport source (output valid, world_x, world_y, world_z, input ready);
   modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface drb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [drb_pkg::CSR_IDX_W-1:0]       index;
   logic [drb_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/drb_stride_rem.sv
`default_nettype none

module drb_stride_rem (
   input  logic                           clock,
   input  drb_pkg::stage_vec_type         stage_en,
   input  logic [drb_pkg::DIV_W-1:0]      col_offset,
   input  logic [drb_pkg::DIV_W-1:0]      row_offset,
   input  logic [drb_pkg::STRIDE_W-1:0]   stride,
   output logic                           aligned
);
   import drb_pkg::*;

   logic [STRIDE_W-1:0] rem_ff [2][REM_STAGES];
   logic [STRIDE_W-1:0] rem_in [2][REM_STAGES];
   logic [DIV_W-1:0]    div_ff [2][REM_STAGES];
   logic [DIV_W-1:0]    div_in [2][REM_STAGES];

   always_comb begin
      logic [STRIDE_W:0]   trial;
      logic [STRIDE_W-1:0] r;
      logic [DIV_W-1:0]    d;
      for (int a = 0; a < 2; a++) begin
         for (int s = 0; s < REM_STAGES; s++) begin
            if (s == 0) begin
               r = '0;
               d = (a == 0) ? col_offset : row_offset;
            end else begin
               r = rem_ff[a][(s == 0) ? 0 : s - 1];
               d = div_ff[a][(s == 0) ? 0 : s - 1];
            end
            for (int j = 0; j < REM_STEPS; j++) begin
               trial = {r, d[DIV_W-1]};
               d = d << 1;
               if (trial >= {1'b0, stride}) begin
                  trial = trial - {1'b0, stride};
               end
               r = trial[STRIDE_W-1:0];
            end
            rem_in[a][s] = r;
            div_in[a][s] = d;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         for (int s = 0; s < REM_STAGES; s++) begin
            if (stage_en[ST_REM_FIRST + s]) begin
               rem_ff[a][s] <= rem_in[a][s];
               div_ff[a][s] <= div_in[a][s];
            end
         end
      end
   end

   assign aligned = (rem_ff[0][REM_STAGES-1] == '0) && (rem_ff[1][REM_STAGES-1] == '0);

endmodule

`default_nettype wire

### rtl/drb_cam_axis.sv
`default_nettype none

module drb_cam_axis (
   input  logic                              clock,
   input  drb_pkg::stage_vec_type            stage_en,
   input  logic [drb_pkg::U_W-1:0]           scaled_pos,
   input  logic [drb_pkg::CENTRE_W-1:0]      centre,
   input  logic [drb_pkg::INVF_W-1:0]        inv_focal,
   input  logic [drb_pkg::DEPTH_W-1:0]       depth,
   output logic signed [drb_pkg::CAM_W-1:0]  cam
);
   import drb_pkg::*;

   logic              neg_ff [4];
   logic              neg_in;
   logic [MAG_W-1:0]  mag_ff;
   logic [MAG_W-1:0]  mag_in;
   logic [P_W-1:0]    p_ff;
   logic [P_W-1:0]    p_in;
   logic [T_W-1:0]    t_ff;
   logic [T_W-1:0]    t_in;
   logic [Q_W-1:0]    q_ff;
   logic [Q_W-1:0]    q_in;
   logic signed [CAM_W-1:0] cam_ff;
   logic signed [CAM_W-1:0] cam_in;

   logic [DU_W-1:0]   du;
   logic [DU_W-1:0]   abs_du;
   logic [P_W:0]      p_round;
   logic [Q_W:0]      q_round;
   logic [C_W-1:0]    c_mag;

   // centred position, split into sign and magnitude
   assign du     = DU_W'(scaled_pos) - DU_W'({centre, {CENTRE_FRAC{1'b0}}});
   assign neg_in = du[DU_W-1];
   assign abs_du = neg_in ? (~du + 1'b1) : du;
   assign mag_in = abs_du[MAG_W-1:0];

   assign p_in = P_W'(mag_ff) * P_W'(inv_focal);

   assign p_round = {1'b0, p_ff} + {{(P_W+1-INVF_SHIFT){1'b0}}, 1'b1, {(INVF_SHIFT-1){1'b0}}};
   assign t_in    = p_round[P_W:INVF_SHIFT];

   assign q_in = Q_W'(t_ff) * Q_W'(depth);

   assign q_round = {1'b0, q_ff} + {{(Q_W+1-CAM_SHIFT){1'b0}}, 1'b1, {(CAM_SHIFT-1){1'b0}}};
   assign c_mag   = q_round[Q_W:CAM_SHIFT];
   assign cam_in  = neg_ff[3] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         neg_ff[0] <= neg_in;
         mag_ff    <= mag_in;
      end
      if (stage_en[ST_PROD]) begin
         neg_ff[1] <= neg_ff[0];
         p_ff      <= p_in;
      end
      if (stage_en[ST_TRUNC]) begin
         neg_ff[2] <= neg_ff[1];
         t_ff      <= t_in;
      end
      if (stage_en[ST_SCALE]) begin
         neg_ff[3] <= neg_ff[2];
         q_ff      <= q_in;
      end
      if (stage_en[ST_CAM]) begin
         cam_ff <= cam_in;
      end
   end

   assign cam = cam_ff;

endmodule

`default_nettype wire

### rtl/drb_world_axis.sv
`default_nettype none

module drb_world_axis (
   input  logic                               clock,
   input  drb_pkg::stage_vec_type             stage_en,
   input  logic signed [drb_pkg::CAM_W-1:0]   cam_x,
   input  logic signed [drb_pkg::CAM_W-1:0]   cam_y,
   input  logic signed [drb_pkg::CAM_W-1:0]   cam_z,
   input  logic [drb_pkg::CSR_DATA_W-1:0]     coef_row,
   output logic signed [drb_pkg::OUT_BITS-1:0] world
);
   import drb_pkg::*;

   logic signed [COEF_W-1:0] coef [3];
   logic signed [PR_W-1:0]   prod_ff [3];
   logic signed [PR_W-1:0]   prod_in [3];
   logic signed [COEF_W-1:0] trans_ff;
   logic signed [W_W-1:0]    trans_term;
   logic signed [W_W-1:0]    w_ff;
   logic signed [W_W-1:0]    w_in;
   logic [W_W-1:0]           bias;
   logic [W_W-1:0]           w_round;
   logic signed [R_W-1:0]    rounded;
   logic signed [R_W-1:0]    sat_hi;
   logic signed [R_W-1:0]    sat_lo;
   logic signed [OUT_BITS-1:0] world_ff;
   logic signed [OUT_BITS-1:0] world_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         coef[i] = coef_row[COEF_W*i +: COEF_W];
      end
   end

   assign prod_in[0] = coef[0] * cam_x;
   assign prod_in[1] = coef[1] * cam_y;
   assign prod_in[2] = coef[2] * cam_z;

   assign trans_term = {{(W_W-COEF_W-WORLD_SHIFT){trans_ff[COEF_W-1]}}, trans_ff,
                        {WORLD_SHIFT{1'b0}}};
   assign w_in = W_W'(prod_ff[0]) + W_W'(prod_ff[1]) + W_W'(prod_ff[2]) + trans_term;

   // round half away from zero: negative values take one less than half
   assign bias = w_ff[W_W-1] ?
                 {{(W_W-WORLD_SHIFT+1){1'b0}}, {(WORLD_SHIFT-1){1'b1}}} :
                 {{(W_W-WORLD_SHIFT){1'b0}}, 1'b1, {(WORLD_SHIFT-1){1'b0}}};
   assign w_round = w_ff + bias;
   assign rounded = w_round[W_W-1:WORLD_SHIFT];

   assign sat_hi = {{(R_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
   assign sat_lo = {{(R_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

   always_comb begin
      if (rounded > sat_hi) begin
         world_in = sat_hi[OUT_BITS-1:0];
      end else if (rounded < sat_lo) begin
         world_in = sat_lo[OUT_BITS-1:0];
      end else begin
         world_in = rounded[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ROT]) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         trans_ff <= coef_row[CSR_DATA_W-1 -: COEF_W];
      end
      if (stage_en[ST_SUM]) begin
         w_ff <= w_in;
      end
      if (stage_en[ST_OUT]) begin
         world_ff <= world_in;
      end
   end

   assign world = world_ff;

endmodule

`default_nettype wire

### rtl/depth_roi_backprojection_core.sv
// Depth ROI back-projection core.
// req_bus carries one depth sample per word (depth, column, row). Samples
// outside the region of interest, off the stride grid or outside the depth
// range are dropped and give no word on rsp_bus. A kept sample leaves on
// rsp_bus as world_x, world_y, world_z in mm, rounded and saturated.
// csr_bus writes the seven configuration registers by index; it is always
// ready and is to be written only while no sample is in flight.
// Throughput: one sample per cycle while rsp_bus is not stalled. The
// pipeline has nine register stages (input, four stride-remainder/
// unprojection stages, camera point, rotation products, sum, round and
// saturate), and a result word is shown on rsp_bus from the last of them.
// Each stage holds a valid bit; a stage moves on when it is empty or the
// next one moves. A stalled rsp_bus therefore fills the bubbles first and
// only then drops req_bus.ready; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: empty region, full depth range, unit pixel scale,
// zero centre and focal reciprocals, identity transform.
`default_nettype none

module depth_roi_backprojection_core (
   input  logic      clock,
   input  logic      reset,
   drb_req_if.sink   req_bus,
   drb_rsp_if.source rsp_bus,
   drb_csr_if.sink   csr_bus
);
   import drb_pkg::*;

   logic [ROI_REG_W-1:0]  roi_ff;
   logic [RANGE_W-1:0]    range_ff;
   logic [CSR_DATA_W-1:0] geom_ff;
   logic [CSR_DATA_W-1:0] invf_ff;
   logic [CSR_DATA_W-1:0] rowx_ff;
   logic [CSR_DATA_W-1:0] rowy_ff;
   logic [CSR_DATA_W-1:0] rowz_ff;

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type stage_en;

   logic [CMP_W-1:0]    col_c, row_c, xs_c, ys_c, xe_c, ye_c;
   logic [DEPTH_W-1:0]  dmin, dmax;
   logic [STRIDE_W-1:0] stride_raw, stride_eff;
   logic                ok_in;
   logic [DIV_W-1:0]    dx_in, dy_in;
   logic [U_W-1:0]      ux_in, uy_in;

   logic                ok_ff    [ST_REM_LAST+1];
   logic [DEPTH_W-1:0]  depth_ff [ST_CAM];
   logic [DIV_W-1:0]    dx_ff, dy_ff;
   logic [U_W-1:0]      ux_ff, uy_ff;
   logic                aligned;
   logic                keep;

   logic signed [CAM_W-1:0] cam_x, cam_y;
   logic signed [CAM_W-1:0] cam_z_ff;
   logic signed [CAM_W-1:0] cam_z_in;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         roi_ff   <= ROI_RESET;
         range_ff <= RANGE_RESET;
         geom_ff  <= GEOM_RESET;
         invf_ff  <= INVF_RESET;
         rowx_ff  <= ROWX_RESET;
         rowy_ff  <= ROWY_RESET;
         rowz_ff  <= ROWZ_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_ROI:   roi_ff   <= csr_bus.data[ROI_REG_W-1:0];
            CSR_RANGE: range_ff <= csr_bus.data[RANGE_W-1:0];
            CSR_GEOM:  geom_ff  <= csr_bus.data;
            CSR_INVF:  invf_ff  <= csr_bus.data;
            CSR_ROW_X: rowx_ff  <= csr_bus.data;
            CSR_ROW_Y: rowy_ff  <= csr_bus.data;
            CSR_ROW_Z: rowz_ff  <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // region, depth range and grid offsets
   assign col_c = CMP_W'(req_bus.column);
   assign row_c = CMP_W'(req_bus.row);
   assign xs_c  = CMP_W'(roi_ff[ROI_W-1:0]);
   assign ys_c  = CMP_W'(roi_ff[2*ROI_W-1:ROI_W]);
   assign xe_c  = CMP_W'(roi_ff[3*ROI_W-1:2*ROI_W]);
   assign ye_c  = CMP_W'(roi_ff[4*ROI_W-1:3*ROI_W]);
   assign dmin  = range_ff[DEPTH_W-1:0];
   assign dmax  = range_ff[2*DEPTH_W-1:DEPTH_W];

   assign stride_raw = roi_ff[ROI_REG_W-1 -: STRIDE_W];
   assign stride_eff = (stride_raw == '0) ? STRIDE_W'(1) : stride_raw;

   assign ok_in = (col_c >= xs_c) && (col_c < xe_c) && (row_c >= ys_c) && (row_c < ye_c) &&
                  (req_bus.depth >= dmin) && (req_bus.depth <= dmax);
   assign dx_in = DIV_W'(col_c - xs_c);
   assign dy_in = DIV_W'(row_c - ys_c);
   assign ux_in = U_W'(req_bus.column) * U_W'(geom_ff[SCALE_W-1:0]);
   assign uy_in = U_W'(req_bus.row) * U_W'(geom_ff[2*SCALE_W-1:SCALE_W]);

   // stage handshake: a stage loads when empty or when its successor loads
   always_comb begin
      stage_en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_bus.ready;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign keep = ok_ff[ST_REM_LAST] && aligned;

   always_comb begin
      valid_in[ST_IN] = req_bus.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      valid_in[ST_CAM] = valid_ff[ST_CAM-1] && keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         ok_ff[0]    <= ok_in;
         depth_ff[0] <= req_bus.depth;
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         ux_ff       <= ux_in;
         uy_ff       <= uy_in;
      end
      for (int k = 1; k < ST_CAM; k++) begin
         if (stage_en[k]) begin
            ok_ff[k]    <= ok_ff[k-1];
            depth_ff[k] <= depth_ff[k-1];
         end
      end
      if (stage_en[ST_CAM]) begin
         cam_z_ff <= cam_z_in;
      end
   end

   assign cam_z_in = $signed({{(CAM_W-DEPTH_W-CAM_SHIFT){1'b0}}, depth_ff[ST_CAM-1],
                              {CAM_SHIFT{1'b0}}});

   drb_stride_rem u_stride_rem (
      .clock      (clock),
      .stage_en   (stage_en),
      .col_offset (dx_ff),
      .row_offset (dy_ff),
      .stride     (stride_eff),
      .aligned    (aligned)
   );

   drb_cam_axis u_cam_x (
      .clock      (clock),
      .stage_en   (stage_en),
      .scaled_pos (ux_ff),
      .centre     (geom_ff[2*SCALE_W+CENTRE_W-1:2*SCALE_W]),
      .inv_focal  (invf_ff[INVF_W-1:0]),
      .depth      (depth_ff[ST_TRUNC]),
      .cam        (cam_x)
   );

   drb_cam_axis u_cam_y (
      .clock      (clock),
      .stage_en   (stage_en),
      .scaled_pos (uy_ff),
      .centre     (geom_ff[CSR_DATA_W-1 -: CENTRE_W]),
      .inv_focal  (invf_ff[CSR_DATA_W-1 -: INVF_W]),
      .depth      (depth_ff[ST_TRUNC]),
      .cam        (cam_y)
   );

   drb_world_axis u_world_x (
      .clock    (clock),
      .stage_en (stage_en),
      .cam_x    (cam_x),
      .cam_y    (cam_y),
      .cam_z    (cam_z_ff),
      .coef_row (rowx_ff),
      .world    (rsp_bus.world_x)
   );

   drb_world_axis u_world_y (
      .clock    (clock),
      .stage_en (stage_en),
      .cam_x    (cam_x),
      .cam_y    (cam_y),
      .cam_z    (cam_z_ff),
      .coef_row (rowy_ff),
      .world    (rsp_bus.world_y)
   );

   drb_world_axis u_world_z (
      .clock    (clock),
      .stage_en (stage_en),
      .cam_x    (cam_x),
      .cam_y    (cam_y),
      .cam_z    (cam_z_ff),
      .coef_row (rowz_ff),
      .world    (rsp_bus.world_z)
   );

   assign req_bus.ready = stage_en[ST_IN];
   assign rsp_bus.valid = valid_ff[ST_OUT];

endmodule

`default_nettype wire
